>>> sv/tqc_pkg.sv
package tqc_pkg;

  localparam int WAYS    = 16;
  localparam int KEY_W   = 32;
  localparam int SIZE_W  = 8;
  localparam int SPACE_W = 12;
  localparam int CNT_W   = $clog2(WAYS + 1);
  localparam int IDX_W   = $clog2(WAYS);

  // queue operation codes
  localparam logic [1:0] OP_NONE        = 2'd0;
  localparam logic [1:0] OP_APPEND      = 2'd1;
  localparam logic [1:0] OP_DROP        = 2'd2;
  localparam logic [1:0] OP_DROP_APPEND = 2'd3;

  // outcome codes
  localparam logic [1:0] OUT_MISS     = 2'd0;
  localparam logic [1:0] OUT_FIFO_HIT = 2'd1;
  localparam logic [1:0] OUT_LRU_HIT  = 2'd2;

  // queue select
  localparam logic Q_FIFO = 1'b0;
  localparam logic Q_LRU  = 1'b1;

  typedef struct packed {
    logic [1:0]        kind;
    logic [IDX_W-1:0]  idx;
    logic [KEY_W-1:0]  tag;
    logic [SIZE_W-1:0] size;
  } tqc_op_t;

  typedef struct packed {
    logic [CNT_W-1:0]   count;
    logic [SPACE_W-1:0] space;
    logic               hit;
    logic [IDX_W-1:0]   hit_idx;
    logic [SIZE_W-1:0]  hit_size;
    logic [KEY_W-1:0]   front_tag;
  } tqc_stat_t;

endpackage

>>> sv/two_queue_cache_replacement.sv
// Channel | Dir | Handshake           | Payload
// req     | in  | req_valid/req_stall | key, item_size
// rsp     | out | rsp_valid/rsp_stall | outcome, evict_valid, evicted_key, evicted_queue, last
// apb     | in  | psel/penable/pready | paddr, pwdata, pwrite, prdata
//
// An LRU hit passes through lookup, final beat and idle; a miss or a promotion
// passes through lookup, insert, the eviction loop (one beat per eviction, up to
// 16 evictions), final beat and idle. When the target queue is full the insert step
// carries the first eviction.
// Reset (rst, synchronous) empties both queues and loads capacities 14 and 2.
// A stalled result beat holds the sequencer for that cycle; no request is taken until
// the final beat of the previous one has been registered.
module two_queue_cache_replacement (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  logic [tqc_pkg::KEY_W-1:0]  key,
  input  logic [tqc_pkg::SIZE_W-1:0] item_size,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output logic [1:0]                 outcome,
  output logic                       evict_valid,
  output logic [tqc_pkg::KEY_W-1:0]  evicted_key,
  output logic                       evicted_queue,
  output logic                       last,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import tqc_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOOK  = 3'd1;
  localparam logic [2:0] S_ADD   = 3'd2;
  localparam logic [2:0] S_EVICT = 3'd3;
  localparam logic [2:0] S_FINAL = 3'd4;

  logic [2:0]         state, state_next;
  logic [KEY_W-1:0]   key_r;
  logic [SIZE_W-1:0]  size_r;
  logic [SIZE_W-1:0]  psize, psize_next;
  logic [1:0]         outcome_r, outcome_next;
  logic               qsel, qsel_next;
  logic [CNT_W-1:0]   n, n_next;
  logic [SPACE_W-1:0] lru_cap;
  logic [SPACE_W-1:0] fifo_cap;

  tqc_op_t   fifo_op, lru_op, op;
  tqc_stat_t fifo_st, lru_st, st;

  logic             can_emit;
  logic             emit;
  logic             emit_evict;
  logic [KEY_W-1:0] emit_key;
  logic             over;
  logic             req_take;

  tqc_queue u_fifo (.clk(clk), .rst(rst), .op(fifo_op), .key(key_r), .stat(fifo_st));
  tqc_queue u_lru  (.clk(clk), .rst(rst), .op(lru_op),  .key(key_r), .stat(lru_st));

  // configuration port
  assign pready = 1'b1;
  assign prdata = paddr[2] ? {{(32-SPACE_W){1'b0}}, fifo_cap}
                           : {{(32-SPACE_W){1'b0}}, lru_cap};

  always_ff @(posedge clk) begin
    if (rst) begin
      lru_cap  <= SPACE_W'(14);
      fifo_cap <= SPACE_W'(2);
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2]) fifo_cap <= pwdata[SPACE_W-1:0];
      else          lru_cap  <= pwdata[SPACE_W-1:0];
    end
  end

  assign req_stall = (state != S_IDLE);
  assign req_take  = req_valid && !req_stall;
  assign can_emit  = !rsp_valid || !rsp_stall;
  assign st        = qsel ? lru_st : fifo_st;
  assign over      = qsel ? (st.space > lru_cap) : (st.space >= fifo_cap);

  // sequencer
  always_comb begin
    state_next   = state;
    psize_next   = psize;
    outcome_next = outcome_r;
    qsel_next    = qsel;
    n_next       = n;
    op           = '0;
    fifo_op      = '0;
    lru_op       = '0;
    emit         = 1'b0;
    emit_evict   = 1'b0;
    emit_key     = '0;
    unique case (state)
      S_IDLE: begin
        if (req_take) state_next = S_LOOK;
      end
      S_LOOK: begin
        if (lru_st.hit) begin
          lru_op.kind  = OP_DROP_APPEND;
          lru_op.idx   = lru_st.hit_idx;
          lru_op.tag   = key_r;
          lru_op.size  = lru_st.hit_size;
          outcome_next = OUT_LRU_HIT;
          state_next   = S_FINAL;
        end else if (fifo_st.hit) begin
          fifo_op.kind = OP_DROP;
          fifo_op.idx  = fifo_st.hit_idx;
          psize_next   = fifo_st.hit_size;
          outcome_next = OUT_FIFO_HIT;
          qsel_next    = Q_LRU;
          state_next   = S_ADD;
        end else begin
          psize_next   = size_r;
          outcome_next = OUT_MISS;
          qsel_next    = Q_FIFO;
          state_next   = S_ADD;
        end
      end
      S_ADD: begin
        op.tag  = key_r;
        op.size = psize;
        if (st.count == CNT_W'(WAYS)) begin
          if (can_emit) begin
            op.kind    = OP_DROP_APPEND;
            emit       = 1'b1;
            emit_evict = 1'b1;
            emit_key   = st.front_tag;
            n_next     = CNT_W'(1);
            state_next = S_EVICT;
          end
        end else begin
          op.kind    = OP_APPEND;
          n_next     = '0;
          state_next = S_EVICT;
        end
      end
      S_EVICT: begin
        if (over && st.count != '0 && n != CNT_W'(WAYS)) begin
          if (can_emit) begin
            op.kind    = OP_DROP;
            emit       = 1'b1;
            emit_evict = 1'b1;
            emit_key   = st.front_tag;
            n_next     = n + CNT_W'(1);
          end
        end else begin
          state_next = S_FINAL;
        end
      end
      S_FINAL: begin
        if (can_emit) begin
          emit       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    // route the shared operation to the selected queue
    if (state == S_ADD || state == S_EVICT) begin
      if (qsel) lru_op = op;
      else      fifo_op = op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      qsel  <= Q_FIFO;
      n     <= '0;
    end else begin
      state <= state_next;
      qsel  <= qsel_next;
      n     <= n_next;
    end
  end

  // hold request payload and working values
  always_ff @(posedge clk) begin
    if (req_take) begin
      key_r  <= key;
      size_r <= item_size;
    end
    psize     <= psize_next;
    outcome_r <= outcome_next;
  end

  // output register: load a beat, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (emit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      outcome       <= outcome_r;
      evict_valid   <= emit_evict;
      evicted_key   <= emit_key;
      evicted_queue <= emit_evict & qsel;
      last          <= !emit_evict;
    end
  end

`ifndef SYNTH
  a_take_look: assert property (@(posedge clk) disable iff (rst)
    req_take |=> state == S_LOOK) else $error("request not looked up");
  a_evict_bound: assert property (@(posedge clk) disable iff (rst)
    n <= CNT_W'(WAYS)) else $error("eviction count beyond ways");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_st.count <= CNT_W'(WAYS) && lru_st.count <= CNT_W'(WAYS))
    else $error("queue overfilled");
  a_final_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINAL && can_emit) |=> (state == S_IDLE && rsp_valid && last))
    else $error("final beat lost");
`endif

endmodule

>>> sv/tqc_cell.sv
module tqc_cell (
  input  logic                      clk,
  input  logic                      shift,
  input  logic                      load,
  input  logic                      live,
  input  logic [tqc_pkg::KEY_W-1:0]  nb_tag,
  input  logic [tqc_pkg::SIZE_W-1:0] nb_size,
  input  logic [tqc_pkg::KEY_W-1:0]  new_tag,
  input  logic [tqc_pkg::SIZE_W-1:0] new_size,
  input  logic [tqc_pkg::KEY_W-1:0]  key,
  output logic [tqc_pkg::KEY_W-1:0]  tag,
  output logic [tqc_pkg::SIZE_W-1:0] size,
  output logic                      match
);
  import tqc_pkg::*;

  // take a new entry, or the neighbour's entry when the row closes a gap
  always_ff @(posedge clk) begin
    if (load) begin
      tag  <= new_tag;
      size <= new_size;
    end else if (shift) begin
      tag  <= nb_tag;
      size <= nb_size;
    end
  end

  assign match = live && (tag == key);

endmodule

>>> sv/tqc_queue.sv
module tqc_queue (
  input  logic               clk,
  input  logic               rst,
  input  tqc_pkg::tqc_op_t   op,
  input  logic [tqc_pkg::KEY_W-1:0] key,
  output tqc_pkg::tqc_stat_t stat
);
  import tqc_pkg::*;

  logic [KEY_W-1:0]   tags  [WAYS];
  logic [SIZE_W-1:0]  sizes [WAYS];
  logic [WAYS-1:0]    match;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic [SPACE_W-1:0] space;
  logic [SPACE_W-1:0] space_next;
  logic [SIZE_W-1:0]  drop_size;
  logic               is_drop;
  logic [CNT_W-1:0]   last_pos;

  assign is_drop   = (op.kind == OP_DROP) || (op.kind == OP_DROP_APPEND);
  assign last_pos  = count - CNT_W'(1);
  assign drop_size = sizes[op.idx];

  // row of cells, each but the last fed by its younger neighbour
  for (genvar k = 0; k < WAYS; k++) begin : g_cell
    logic shift_k;
    logic load_k;
    logic live_k;
    logic [KEY_W-1:0]  nb_tag_k;
    logic [SIZE_W-1:0] nb_size_k;

    assign shift_k = is_drop && (IDX_W'(k) >= op.idx);
    assign load_k  = ((op.kind == OP_APPEND) && (CNT_W'(k) == count)) ||
                     ((op.kind == OP_DROP_APPEND) && (CNT_W'(k) == last_pos));
    assign live_k  = CNT_W'(k) < count;

    if (k == WAYS - 1) begin : g_end
      assign nb_tag_k  = tags[k];
      assign nb_size_k = sizes[k];
    end else begin : g_mid
      assign nb_tag_k  = tags[k+1];
      assign nb_size_k = sizes[k+1];
    end

    tqc_cell u_cell (
      .clk      (clk),
      .shift    (shift_k),
      .load     (load_k),
      .live     (live_k),
      .nb_tag   (nb_tag_k),
      .nb_size  (nb_size_k),
      .new_tag  (op.tag),
      .new_size (op.size),
      .key      (key),
      .tag      (tags[k]),
      .size     (sizes[k]),
      .match    (match[k])
    );
  end

  // pick the oldest matching cell and report the queue state
  always_comb begin
    stat.count   = count;
    stat.space   = space;
    stat.hit     = 1'b0;
    stat.hit_idx = '0;
    for (int k = WAYS - 1; k >= 0; k--) begin
      if (match[k]) begin
        stat.hit     = 1'b1;
        stat.hit_idx = IDX_W'(k);
      end
    end
    stat.hit_size  = sizes[stat.hit_idx];
    stat.front_tag = tags[0];
  end

  // track fill count and occupied space
  always_comb begin
    count_next = count;
    space_next = space;
    case (op.kind)
      OP_APPEND: begin
        count_next = count + CNT_W'(1);
        space_next = space + SPACE_W'(op.size);
      end
      OP_DROP: begin
        count_next = count - CNT_W'(1);
        space_next = space - SPACE_W'(drop_size);
      end
      OP_DROP_APPEND: begin
        space_next = space - SPACE_W'(drop_size) + SPACE_W'(op.size);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      space <= '0;
    end else begin
      count <= count_next;
      space <= space_next;
    end
  end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import tqc_pkg::*;

  localparam logic [2:0] ADDR_LRU_CAP  = 3'd0;
  localparam logic [2:0] ADDR_FIFO_CAP = 3'd4;
  localparam int POOL      = 24;
  localparam int PHASE_LEN = 60;
  localparam int LIMIT     = 400000;
  localparam int SETTLE    = 24;

  typedef struct {
    logic [KEY_W-1:0]  tag;
    logic [SIZE_W-1:0] size;
  } entry_t;

  typedef struct {
    logic [1:0]       outcome;
    logic             evict_valid;
    logic [KEY_W-1:0] evicted_key;
    logic             evicted_queue;
    logic             last;
  } beat_t;

  typedef struct {
    logic [KEY_W-1:0]  key;
    logic [SIZE_W-1:0] size;
    bit                typed;
    logic [1:0]        outcome;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  logic [KEY_W-1:0] key = '0;
  logic [SIZE_W-1:0] item_size = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  logic [1:0] outcome;
  logic evict_valid;
  logic [KEY_W-1:0] evicted_key;
  logic evicted_queue;
  logic last;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // predictor state
  entry_t probation_q[$];
  entry_t protected_q[$];
  int probation_used;
  int protected_used;
  logic [SPACE_W-1:0] lru_cap = 12'd14;
  logic [SPACE_W-1:0] fifo_cap = 12'd2;

  beat_t pending_beats[$];
  bit typed_outcome_on[$];
  logic [1:0] typed_outcome[$];
  int errors = 0;
  int cycles = 0;
  bit calm = 1'b0;
  logic [KEY_W-1:0] key_pool[POOL];

  two_queue_cache_replacement dut (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic report(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    errors++;
  endtask

  // evict the oldest entry of one queue and queue its beat
  function automatic void evict_oldest(input bit from_lru, input logic [1:0] oc,
                                       inout int n);
    entry_t e;
    if (from_lru) begin
      if (protected_q.size() == 0) return;
      e = protected_q.pop_front();
      protected_used -= e.size;
    end else begin
      if (probation_q.size() == 0) return;
      e = probation_q.pop_front();
      probation_used -= e.size;
    end
    pending_beats.insert(pending_beats.size(), beat_t'{oc, 1'b1, e.tag, from_lru, 1'b0});
    n++;
  endfunction

  function automatic void predict_access(input logic [KEY_W-1:0] k,
                                         input logic [SIZE_W-1:0] sz);
    int idx;
    int n;
    entry_t e;
    logic [1:0] oc;
    idx = -1;
    n = 0;
    foreach (protected_q[i]) if (idx < 0 && protected_q[i].tag == k) idx = i;
    if (idx >= 0) begin
      oc = OUT_LRU_HIT;
      e = protected_q[idx];
      protected_q.delete(idx);
      protected_q.insert(protected_q.size(), e);
    end else begin
      foreach (probation_q[i]) if (idx < 0 && probation_q[i].tag == k) idx = i;
      if (idx >= 0) begin
        // promote: leave probation, join the protected end
        oc = OUT_FIFO_HIT;
        e = probation_q[idx];
        probation_q.delete(idx);
        probation_used -= e.size;
        if (protected_q.size() >= WAYS) evict_oldest(Q_LRU, oc, n);
        protected_q.insert(protected_q.size(), e);
        protected_used += e.size;
        while (protected_used > lru_cap && protected_q.size() > 0 && n < WAYS)
          evict_oldest(Q_LRU, oc, n);
      end else begin
        oc = OUT_MISS;
        if (probation_q.size() >= WAYS) evict_oldest(Q_FIFO, oc, n);
        probation_q.insert(probation_q.size(), entry_t'{k, sz});
        probation_used += sz;
        while (probation_used >= fifo_cap && probation_q.size() > 0 && n < WAYS)
          evict_oldest(Q_FIFO, oc, n);
      end
    end
    pending_beats.insert(pending_beats.size(), beat_t'{oc, 1'b0, '0, 1'b0, 1'b1});
  endfunction

  // result side: random stall, compare every accepted beat
  always @(posedge clk) begin
    rsp_stall <= calm ? 1'b0 : ($urandom_range(99) < 29);
  end

  always @(posedge clk) begin
    beat_t b;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_beats.size() == 0) begin
        report("result beat with nothing outstanding");
      end else begin
        b = pending_beats.pop_front();
        if (outcome !== b.outcome)
          report($sformatf("outcome %0d, want %0d", outcome, b.outcome));
        if (evict_valid !== b.evict_valid)
          report($sformatf("evict_valid %0b, want %0b", evict_valid, b.evict_valid));
        if (evicted_key !== b.evicted_key)
          report($sformatf("evicted_key %h, want %h", evicted_key, b.evicted_key));
        if (evicted_queue !== b.evicted_queue)
          report($sformatf("evicted_queue %0b, want %0b", evicted_queue, b.evicted_queue));
        if (last !== b.last)
          report($sformatf("last %0b, want %0b", last, b.last));
        if (b.last && typed_outcome_on.size() > 0) begin
          if (typed_outcome_on.pop_front() && outcome !== typed_outcome[0])
            report($sformatf("outcome %0d, table says %0d", outcome, typed_outcome[0]));
          void'(typed_outcome.pop_front());
        end
      end
    end
  end

  task automatic send_request(input logic [KEY_W-1:0] k, input logic [SIZE_W-1:0] sz,
                              input bit typed, input logic [1:0] oc);
    while (!calm && $urandom_range(99) < 29) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    key <= k;
    item_size <= sz;
    do @(posedge clk); while (req_stall);
    typed_outcome_on.insert(typed_outcome_on.size(), typed);
    typed_outcome.insert(typed_outcome.size(), oc);
    predict_access(k, sz);
  endtask

  // hold until every beat is in, then let the sequencer settle
  task automatic drain;
    req_valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [SPACE_W-1:0] val);
    logic [31:0] rd;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= {20'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (addr == ADDR_LRU_CAP) lru_cap = val;
    else fifo_cap = val;
    // read back
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (rd[SPACE_W-1:0] !== val)
      report($sformatf("register %0d reads %h, want %h", addr, rd, val));
  endtask

  stim_row_t directed[] = '{
    // reset capacities: tiny probation threshold
    '{32'h0000_0000, 8'd1,   1'b1, OUT_MISS},
    '{32'hFFFF_FFFF, 8'd255, 1'b1, OUT_MISS},
    '{32'h0000_0001, 8'd0,   1'b1, OUT_MISS},
    '{32'h0000_0001, 8'd7,   1'b1, OUT_FIFO_HIT},
    '{32'h0000_0001, 8'd9,   1'b1, OUT_LRU_HIT},
    // wide probation from here: fill it past full
    '{32'h0000_0010, 8'd10, 1'b1, OUT_MISS},
    '{32'h0000_0011, 8'd10, 1'b1, OUT_MISS},
    '{32'h0000_0012, 8'd10, 1'b1, OUT_MISS},
    '{32'h0000_0013, 8'd10, 1'b1, OUT_MISS},
    '{32'h0000_0014, 8'd10, 1'b1, OUT_MISS},
    '{32'h0000_0015, 8'd10, 1'b1, OUT_MISS},
    '{32'h0000_0016, 8'd10, 1'b1, OUT_MISS},
    '{32'h0000_0017, 8'd10, 1'b1, OUT_MISS},
    '{32'h0000_0018, 8'd10, 1'b1, OUT_MISS},
    '{32'h0000_0019, 8'd10, 1'b1, OUT_MISS},
    '{32'h0000_001A, 8'd10, 1'b1, OUT_MISS},
    '{32'h0000_001B, 8'd10, 1'b1, OUT_MISS},
    '{32'h0000_001C, 8'd10, 1'b1, OUT_MISS},
    '{32'h0000_001D, 8'd10, 1'b1, OUT_MISS},
    '{32'h0000_001E, 8'd10, 1'b1, OUT_MISS},
    '{32'h0000_001F, 8'd10, 1'b1, OUT_MISS},
    '{32'h0000_0020, 8'd10, 1'b0, OUT_MISS},
    '{32'h0000_0011, 8'd99, 1'b0, OUT_MISS},
    '{32'h0000_0012, 8'd0,  1'b0, OUT_MISS},
    '{32'h0000_0015, 8'd3,  1'b0, OUT_MISS}
  };

  logic [SPACE_W-1:0] lru_plan[4];
  logic [SPACE_W-1:0] fifo_plan[4];

  initial begin
    logic [KEY_W-1:0] k;
    logic [SIZE_W-1:0] sz;
    int r;
    foreach (key_pool[i]) key_pool[i] = $urandom;
    lru_plan = '{12'd4095, 12'd0, 12'd300, 12'($urandom_range(4095))};
    fifo_plan = '{12'd4095, 12'd0, 12'd600, 12'($urandom_range(4095))};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    foreach (directed[i]) begin
      if (i == 5) begin
        drain();
        write_reg(ADDR_LRU_CAP, 12'd40);
        write_reg(ADDR_FIFO_CAP, 12'd4095);
      end
      send_request(directed[i].key, directed[i].size, directed[i].typed,
                   directed[i].outcome);
    end

    // random phases, one capacity setting each
    for (int p = 0; p < 4; p++) begin
      drain();
      write_reg(ADDR_LRU_CAP, lru_plan[p]);
      write_reg(ADDR_FIFO_CAP, fifo_plan[p]);
      calm = (p == 2);
      for (int n = 0; n < PHASE_LEN; n++) begin
        r = $urandom_range(99);
        k = (r < 80) ? key_pool[$urandom_range(POOL - 1)] : KEY_W'($urandom);
        r = $urandom_range(99);
        if (r < 10) sz = '0;
        else if (r < 70) sz = SIZE_W'($urandom_range(40, 1));
        else sz = SIZE_W'($urandom_range(255));
        send_request(k, sz, 1'b0, OUT_MISS);
      end
    end
    calm = 1'b0;
    drain();

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
